/* hdl/vtvc_pkg.sv */
// Package for the vertex transform and viewport mapping block.
// Holds the item structs, register indexes and fixed widths; it depends on nothing.
package vtvc_pkg;

  localparam int COORD_W   = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_IN_W  = 12;
  localparam int PIX_W     = 11;
  localparam int OFF_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

  localparam logic [CFG_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
  localparam logic [CFG_W-1:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
  localparam int WIDTH_RESET  = 320;
  localparam int HEIGHT_RESET = 240;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic signed [COORD_W-1:0] vertex_w;
  } vertex_t;

  typedef struct packed {
    logic             visible;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [OFF_W-1:0] byte_offset;
  } pixel_t;

endpackage

/* hdl/vertex_transform_viewport_clip_top.sv */
// Top level of the vertex transform and viewport mapping block.
// Depends on vtvc_pkg for the item structs, register indexes and widths.
//
// Usage: vertices enter on the vtx channel (vtx_valid, vtx_stall, vtx) and
// screen points leave on the pix channel (pix_valid, pix_stall, pix), one
// result item for every vertex item. Each vertex is multiplied by two matrix
// rows, scaled back to Q8.8 with saturation, offset to the screen center and
// clipped against the screen; a visible point also gets its RGB byte offset.
// The datapath is a six stage pipeline: products, sums, shift and saturate,
// screen mapping and clip, row multiply, offset. pix_valid rises when an item
// reaches the offset stage, and one item enters every cycle while the receiver
// takes results.
// A stall on pix holds the last stage; earlier stages keep
// moving into empty slots, so bubbles close up and nothing is lost or repeated.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the pipeline is empty, as the block does not check.
// Screen sizes above MAX_SCREEN_DIM are saturated. Synchronous reset empties
// the pipeline and loads the identity rows and a 320 by 240 screen.
module vertex_transform_viewport_clip_top #(
  parameter int MAX_SCREEN_DIM = 2048,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              vtx_valid,
  output logic                              vtx_stall,
  input  vtvc_pkg::vertex_t                 vtx,
  output logic                              pix_valid,
  input  logic                              pix_stall,
  output vtvc_pkg::pixel_t                  pix,
  input  logic                              cfg_we,
  input  logic [vtvc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vtvc_pkg::CFG_W-1:0]        cfg_data
);

  localparam int DIM_W  = $clog2(MAX_SCREEN_DIM + 1);
  localparam int PROD_W = 2 * vtvc_pkg::COORD_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int SC_W   = (DIM_W + 9 > 18) ? DIM_W + 9 : 18;
  localparam int MUL_W  = 2 * DIM_W;
  localparam int SUM_W  = (2 * DIM_W + 3 > vtvc_pkg::OFF_W) ? 2 * DIM_W + 3 : vtvc_pkg::OFF_W;
  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_SCREEN_DIM);
  localparam logic [DIM_W-1:0] WIDTH_INIT =
    DIM_W'((vtvc_pkg::WIDTH_RESET > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : vtvc_pkg::WIDTH_RESET);
  localparam logic [DIM_W-1:0] HEIGHT_INIT =
    DIM_W'((vtvc_pkg::HEIGHT_RESET > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : vtvc_pkg::HEIGHT_RESET);

  logic [vtvc_pkg::CFG_W-1:0] matrix_row_x;
  logic [vtvc_pkg::CFG_W-1:0] matrix_row_y;
  logic [DIM_W-1:0]           screen_width;
  logic [DIM_W-1:0]           screen_height;
  logic [DIM_W-1:0]           dim_clamped;

  always_comb begin
    if (32'(cfg_data[vtvc_pkg::DIM_IN_W-1:0]) > 32'(MAX_SCREEN_DIM)) begin
      dim_clamped = MAX_DIM;
    end else begin
      dim_clamped = DIM_W'(cfg_data[vtvc_pkg::DIM_IN_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_row_x  <= vtvc_pkg::ROW_X_RESET;
      matrix_row_y  <= vtvc_pkg::ROW_Y_RESET;
      screen_width  <= WIDTH_INIT;
      screen_height <= HEIGHT_INIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vtvc_pkg::REG_MATRIX_ROW_X:  matrix_row_x  <= cfg_data;
        vtvc_pkg::REG_MATRIX_ROW_Y:  matrix_row_y  <= cfg_data;
        vtvc_pkg::REG_SCREEN_WIDTH:  screen_width  <= dim_clamped;
        vtvc_pkg::REG_SCREEN_HEIGHT: screen_height <= dim_clamped;
        default: ;
      endcase
    end
  end

  // Per-stage flow control: a stage loads when it is empty or its successor moves.
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !s6_valid || !pix_stall;
  assign rdy5 = !s5_valid || rdy6;
  assign rdy4 = !s4_valid || rdy5;
  assign rdy3 = !s3_valid || rdy4;
  assign rdy2 = !s2_valid || rdy3;
  assign rdy1 = !s1_valid || rdy2;
  assign vtx_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid <= vtx_valid;
      if (rdy2) s2_valid <= s1_valid;
      if (rdy3) s3_valid <= s2_valid;
      if (rdy4) s4_valid <= s3_valid;
      if (rdy5) s5_valid <= s4_valid;
      if (rdy6) s6_valid <= s5_valid;
    end
  end

  // Stage 1: eight products of coefficient and coordinate.
  logic signed [vtvc_pkg::COORD_W-1:0] coord [4];
  logic signed [PROD_W-1:0]            prod_x [4];
  logic signed [PROD_W-1:0]            prod_y [4];

  assign coord[0] = vtx.vertex_x;
  assign coord[1] = vtx.vertex_y;
  assign coord[2] = vtx.vertex_z;
  assign coord[3] = vtx.vertex_w;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int k = 0; k < 4; k++) begin
        prod_x[k] <= $signed(matrix_row_x[16*k +: 16]) * coord[k];
        prod_y[k] <= $signed(matrix_row_y[16*k +: 16]) * coord[k];
      end
    end
  end

  // Stage 2: dot product sums.
  logic signed [ACC_W-1:0] acc_x, acc_y;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      acc_x <= ACC_W'(prod_x[0]) + ACC_W'(prod_x[1]) + ACC_W'(prod_x[2]) + ACC_W'(prod_x[3]);
      acc_y <= ACC_W'(prod_y[0]) + ACC_W'(prod_y[1]) + ACC_W'(prod_y[2]) + ACC_W'(prod_y[3]);
    end
  end

  // Stage 3: floor shift back to Q8.8 and saturate.
  logic signed [ACC_W-1:0]            sh_x, sh_y;
  logic signed [vtvc_pkg::COORD_W-1:0] tx, ty, tx_next, ty_next;

  assign sh_x = acc_x >>> COEF_FRAC_BITS;
  assign sh_y = acc_y >>> COEF_FRAC_BITS;

  always_comb begin
    if (sh_x > ACC_W'(32767)) begin
      tx_next = 16'sh7FFF;
    end else if (sh_x < -ACC_W'(32768)) begin
      tx_next = -16'sh8000;
    end else begin
      tx_next = sh_x[vtvc_pkg::COORD_W-1:0];
    end
    if (sh_y > ACC_W'(32767)) begin
      ty_next = 16'sh7FFF;
    end else if (sh_y < -ACC_W'(32768)) begin
      ty_next = -16'sh8000;
    end else begin
      ty_next = sh_y[vtvc_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      tx <= tx_next;
      ty <= ty_next;
    end
  end

  // Stage 4: move to screen space and clip.
  logic signed [SC_W-1:0] sx, sy, w_span, h_span;
  logic                   vis_next, vis4;
  logic [DIM_W-1:0]       px4, py4;

  assign w_span = $signed({{(SC_W-DIM_W){1'b0}}, screen_width}) <<< 8;
  assign h_span = $signed({{(SC_W-DIM_W){1'b0}}, screen_height}) <<< 8;
  assign sx = SC_W'(tx) + (w_span >>> 1);
  assign sy = (h_span >>> 1) - SC_W'(ty);
  assign vis_next = !sx[SC_W-1] && !sy[SC_W-1] && (sx < w_span) && (sy < h_span);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      vis4 <= vis_next;
      px4  <= vis_next ? sx[DIM_W+7:8] : '0;
      py4  <= vis_next ? sy[DIM_W+7:8] : '0;
    end
  end

  // Stage 5: row times width.
  logic             vis5;
  logic [DIM_W-1:0] px5, py5;
  logic [MUL_W-1:0] row_base;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      vis5     <= vis4;
      px5      <= px4;
      py5      <= py4;
      row_base <= py4 * screen_width;
    end
  end

  // Stage 6: pixel index times three bytes.
  logic [SUM_W-1:0] pix_index, byte_full;

  assign pix_index = SUM_W'(row_base) + SUM_W'(px5);
  assign byte_full = (pix_index << 1) + pix_index;

  always_ff @(posedge clk) begin
    if (rdy6) begin
      pix.visible     <= vis5;
      pix.pixel_x     <= vtvc_pkg::PIX_W'(px5);
      pix.pixel_y     <= vtvc_pkg::PIX_W'(py5);
      pix.byte_offset <= byte_full[vtvc_pkg::OFF_W-1:0];
    end
  end

  assign pix_valid = s6_valid;

endmodule
